### rtl/annexb_pkg.sv
// Shared types and constants for the Annex B NAL unit extractor.
// No dependencies; used by every module of the block.
`default_nettype none

package annexb_pkg;

  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_START = 8'h01;
  localparam logic [7:0] BYTE_EPB   = 8'h03;

  // zero run counter saturates here ("three or more")
  localparam logic [1:0] ZRUN_MAX   = 2'd3;
  localparam logic [1:0] ZRUN_START = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // Results caused by one input transaction: nz held-back zeros, then an
  // optional tail result (payload byte or end of unit).
  typedef struct packed {
    logic [1:0] nz;
    logic       tail;
    logic [7:0] tail_byte;
    logic       tail_kind;
  } burst_t;

endpackage

`default_nettype wire

### rtl/annexb_decode.sv
// Input register, zero run / unit state and per-byte decode.
// Depends on annexb_pkg.
`default_nettype none

module annexb_decode (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_byte,
  input  wire logic                end_of_stream,
  input  wire logic                load_ok,
  output logic                     load,
  output annexb_pkg::burst_t       desc
);

  logic       inreg_valid;
  logic [7:0] inreg_byte;
  logic       inreg_eos;

  logic [1:0] zero_run;
  logic [1:0] zero_run_next;
  logic       unit_has_bytes;
  logic       unit_has_bytes_next;

  assign load     = inreg_valid && load_ok;
  assign in_ready = !inreg_valid || load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      inreg_valid <= 1'b0;
    end else if (in_ready) begin
      inreg_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      inreg_byte <= in_byte;
      inreg_eos  <= end_of_stream;
    end
  end

  always_comb begin
    desc                = '0;
    desc.tail_kind      = annexb_pkg::KIND_PAYLOAD;
    zero_run_next       = zero_run;
    unit_has_bytes_next = unit_has_bytes;
    if (inreg_eos ||
        (inreg_byte == annexb_pkg::BYTE_START && zero_run >= annexb_pkg::ZRUN_START)) begin
      // close the unit; boundary only if it holds payload
      desc.tail           = unit_has_bytes;
      desc.tail_kind      = annexb_pkg::KIND_END;
      zero_run_next       = '0;
      unit_has_bytes_next = 1'b0;
    end else if (inreg_byte == annexb_pkg::BYTE_ZERO) begin
      if (zero_run != annexb_pkg::ZRUN_MAX) begin
        zero_run_next = zero_run + 2'd1;
      end else begin
        desc.tail           = 1'b1;
        unit_has_bytes_next = 1'b1;
      end
    end else begin
      desc.nz        = zero_run;
      desc.tail      = !(inreg_byte == annexb_pkg::BYTE_EPB &&
                         zero_run >= annexb_pkg::ZRUN_START);
      desc.tail_byte = inreg_byte;
      zero_run_next  = '0;
      unit_has_bytes_next = unit_has_bytes || (zero_run != 2'd0) || desc.tail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run       <= '0;
      unit_has_bytes <= 1'b0;
    end else if (load) begin
      zero_run       <= zero_run_next;
      unit_has_bytes <= unit_has_bytes_next;
    end
  end

endmodule

`default_nettype wire

### rtl/annexb_burst.sv
// Result register: plays out the results of one decoded transaction.
// Depends on annexb_pkg.
`default_nettype none

module annexb_burst (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire annexb_pkg::burst_t  desc,
  output logic                     load_ok,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_byte,
  output logic                     kind,
  output logic                     last_of_run
);

  logic [1:0] nz_left;
  logic       tail_pend;
  logic [7:0] tail_byte;
  logic       tail_kind;

  assign out_valid   = (nz_left != 2'd0) || tail_pend;
  assign last_of_run = (nz_left == 2'd0) || ((nz_left == 2'd1) && !tail_pend);
  assign out_byte    = (nz_left != 2'd0) ? annexb_pkg::BYTE_ZERO : tail_byte;
  assign kind        = (nz_left != 2'd0) ? annexb_pkg::KIND_PAYLOAD : tail_kind;
  assign load_ok     = !out_valid || (last_of_run && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      nz_left   <= '0;
      tail_pend <= 1'b0;
    end else if (load) begin
      nz_left   <= desc.nz;
      tail_pend <= desc.tail;
    end else if (out_valid && out_ready) begin
      if (nz_left != 2'd0) begin
        nz_left <= nz_left - 2'd1;
      end else begin
        tail_pend <= 1'b0;
      end
    end
    if (load) begin
      tail_byte <= desc.tail_byte;
      tail_kind <= desc.tail_kind;
    end
  end

endmodule

`default_nettype wire

### rtl/annexb_nal_unit_extractor_core.sv
// Annex B byte-stream NAL unit extractor, top level.
// Uses annexb_pkg, annexb_decode and annexb_burst.
//
// Input channel (in_valid/in_ready): one bitstream byte per transaction,
// or an end_of_stream marker. Output channel (out_valid/out_ready): payload
// bytes (kind 0) and end-of-unit markers (kind 1); last_of_run flags the
// final result of each input transaction.
// Start codes are stripped, emulation-prevention 0x03 bytes after two or
// more zeros are dropped, zeros are held back until the next byte resolves
// them. Empty units produce no boundary.
// A result passes the input register, then the result register.
// Throughput: one input per cycle while each input gives at most one
// result and out_ready is high; an input that gives n > 1 results holds
// the input side while the result register plays them out, one per cycle
// while out_ready is high. Inputs with no result do not hold the input side.
// Receiver stall: the result register holds; the input register still takes
// one more transaction, then in_ready drops.
// Reset (rst, synchronous): both registers empty, zero run count 0, unit
// empty.
`default_nettype none

module annexb_nal_unit_extractor_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_stream,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            kind,
  output logic            last_of_run
);

  annexb_pkg::burst_t desc;
  logic               load;
  logic               load_ok;

  annexb_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .end_of_stream (end_of_stream),
    .load_ok       (load_ok),
    .load          (load),
    .desc          (desc)
  );

  annexb_burst u_burst (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .desc        (desc),
    .load_ok     (load_ok),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .kind        (kind),
    .last_of_run (last_of_run)
  );

`ifndef SYNTHESIS
  // an end-of-unit marker is always the sole, final result of its run
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == annexb_pkg::KIND_END |-> last_of_run && out_byte == 8'h00)
    else $error("end-of-unit result not last of run or nonzero byte");

  // a run that is not finished keeps going after the transaction
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("result run ended early");

  // held-back zeros come out first when a descriptor is loaded
  a_zeros_first: assert property (@(posedge clk) disable iff (rst)
    load && desc.nz != 2'd0 |=>
      out_valid && kind == annexb_pkg::KIND_PAYLOAD && out_byte == 8'h00)
    else $error("held-back zero not emitted first");
`endif

endmodule

`default_nettype wire
